>>> src/cdf_pkg.sv
// ----------------------------------------------------------------------------
// cdf_pkg
// Shared types and constants of the channel dimmer with fade: command
// codes, status codes, register indexes and the scaling constants.
// ----------------------------------------------------------------------------
package cdf_pkg;

    // Field widths
    localparam int CHAN_W     = 24;
    localparam int BYTE_W     = 8;
    localparam int LVL_W      = 8;
    localparam int LVIN_W     = 9;
    localparam int DUR_W      = 24;
    localparam int TIME_W     = 32;
    localparam int CFG_IDX_W  = 2;

    // Level limits
    localparam logic [LVL_W-1:0]  LEVEL_MAX   = 8'd200;
    localparam logic [LVL_W-1:0]  LEVEL_RESET = 8'd100;
    localparam logic [BYTE_W-1:0] BYTE_MAX    = 8'd255;

    // Rounded divide by 100: floor(x * RECIP_MUL / 2^RECIP_SHIFT), exact for x up to 91180;
    // the largest biased product is 255 * 200 + 50 = 51050
    localparam logic [16:0] ROUND_BIAS  = 17'd50;
    localparam logic [16:0] RECIP_MUL   = 17'd83887;
    localparam int          RECIP_SHIFT = 23;
    localparam logic [15:0] MIN_BOOST   = 16'd20;

    // Fade divider: magnitude of elapsed * delta fits in 41 bits
    localparam int          DIV_W     = 41;
    localparam int          DIV_CNT_W = 6;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = 6'(DIV_W - 1);

    // Command queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    // Request codes on the input
    localparam logic [2:0] REQ_SAMPLE = 3'd0;
    localparam logic [2:0] REQ_TICK   = 3'd1;
    localparam logic [2:0] REQ_SET    = 3'd2;
    localparam logic [2:0] REQ_ADJUST = 3'd3;
    localparam logic [2:0] REQ_FADE   = 3'd4;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_A = 2'd0,
        CFG_LAST_A  = 2'd1,
        CFG_FIRST_B = 2'd2,
        CFG_LAST_B  = 2'd3
    } cfg_idx_t;

    // Decoded operation
    typedef enum logic [2:0] {
        OP_SAMPLE,
        OP_TICK,
        OP_SET,
        OP_ADJUST,
        OP_FADE,
        OP_NONE
    } op_t;

    // Result status
    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_HIGH = 2'd1,
        STAT_LOW  = 2'd2
    } status_t;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCALE,
        ST_DIV,
        ST_FIX
    } back_state_t;

    // Classified command moved from front to back
    typedef struct packed {
        op_t                op;
        logic               excl;
        logic [BYTE_W-1:0]  value;
        logic [LVIN_W-1:0]  level_value;
        logic [DUR_W-1:0]   fade_ms;
        logic [TIME_W-1:0]  now_ms;
    } cmd_t;

endpackage

>>> src/cdf_front.sv
// ----------------------------------------------------------------------------
// cdf_front
// Holds the exclude range registers, decodes the request type and tags
// samples that fall inside an exclude range.
// ----------------------------------------------------------------------------
module cdf_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cdf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cdf_pkg::CHAN_W-1:0]    cfg_data,
    input  logic [2:0]                    req_type,
    input  logic [cdf_pkg::CHAN_W-1:0]    channel_index,
    input  logic [cdf_pkg::BYTE_W-1:0]    channel_value,
    input  logic [cdf_pkg::LVIN_W-1:0]    level_value,
    input  logic [cdf_pkg::DUR_W-1:0]     fade_ms,
    input  logic [cdf_pkg::TIME_W-1:0]    now_ms,
    output cdf_pkg::cmd_t                 cmd
);

    logic [cdf_pkg::CHAN_W-1:0] first_a_reg;
    logic [cdf_pkg::CHAN_W-1:0] last_a_reg;
    logic [cdf_pkg::CHAN_W-1:0] first_b_reg;
    logic [cdf_pkg::CHAN_W-1:0] last_b_reg;
    logic                       in_a;
    logic                       in_b;
    cdf_pkg::op_t               op;

    assign cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_a_reg <= '1;
            last_a_reg  <= '0;
            first_b_reg <= '1;
            last_b_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cdf_pkg::cfg_idx_t'(cfg_index))
                cdf_pkg::CFG_FIRST_A: first_a_reg <= cfg_data;
                cdf_pkg::CFG_LAST_A:  last_a_reg  <= cfg_data;
                cdf_pkg::CFG_FIRST_B: first_b_reg <= cfg_data;
                cdf_pkg::CFG_LAST_B:  last_b_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Check both exclude ranges; an empty range has first above last
    assign in_a = (first_a_reg <= last_a_reg) && (channel_index >= first_a_reg)
                  && (channel_index <= last_a_reg);
    assign in_b = (first_b_reg <= last_b_reg) && (channel_index >= first_b_reg)
                  && (channel_index <= last_b_reg);

    // Decode request type
    always_comb
    begin
        case (req_type)
            cdf_pkg::REQ_SAMPLE: op = cdf_pkg::OP_SAMPLE;
            cdf_pkg::REQ_TICK:   op = cdf_pkg::OP_TICK;
            cdf_pkg::REQ_SET:    op = cdf_pkg::OP_SET;
            cdf_pkg::REQ_ADJUST: op = cdf_pkg::OP_ADJUST;
            cdf_pkg::REQ_FADE:   op = cdf_pkg::OP_FADE;
            default:             op = cdf_pkg::OP_NONE;
        endcase
    end

    // Build the command
    always_comb
    begin
        cmd.op          = op;
        cmd.excl        = in_a || in_b;
        cmd.value       = channel_value;
        cmd.level_value = level_value;
        cmd.fade_ms     = fade_ms;
        cmd.now_ms      = now_ms;
    end

endmodule

>>> src/cdf_queue.sv
// ----------------------------------------------------------------------------
// cdf_queue
// Short command queue between front and back; lets each side stall on
// its own.
// ----------------------------------------------------------------------------
module cdf_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cdf_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output cdf_pkg::cmd_t head
);

    cdf_pkg::cmd_t                    mem_reg [cdf_pkg::QUEUE_DEPTH];
    logic [cdf_pkg::QUEUE_PTR_W-1:0]  wr_ptr_reg;
    logic [cdf_pkg::QUEUE_PTR_W-1:0]  rd_ptr_reg;
    logic [cdf_pkg::QUEUE_CNT_W-1:0]  count_reg;
    logic [cdf_pkg::QUEUE_CNT_W-1:0]  count_next;

    assign full       = (count_reg == cdf_pkg::QUEUE_CNT_W'(cdf_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // Store pushed command
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

>>> src/cdf_back.sv
// ----------------------------------------------------------------------------
// cdf_back
// Carries out commands in order: scales samples, runs the level and fade
// state, steps a restoring divider for fade ticks and drives the result
// register.
// ----------------------------------------------------------------------------
module cdf_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         head_valid,
    input  cdf_pkg::cmd_t                head,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [cdf_pkg::BYTE_W-1:0]   scaled_value,
    output logic [1:0]                   status,
    output logic [cdf_pkg::LVL_W-1:0]    current_level,
    output logic                         fade_running
);

    // Model state
    logic [cdf_pkg::LVL_W-1:0]   level_reg, level_next;
    logic                        fade_on_reg, fade_on_next;
    logic [cdf_pkg::TIME_W-1:0]  fade_begin_time_reg, fade_begin_time_next;
    logic [cdf_pkg::TIME_W-1:0]  fade_finish_time_reg, fade_finish_time_next;
    logic [cdf_pkg::LVL_W-1:0]   fade_begin_level_reg, fade_begin_level_next;
    logic [cdf_pkg::LVL_W-1:0]   fade_target_level_reg, fade_target_level_next;
    logic [cdf_pkg::TIME_W-1:0]  last_tick_reg, last_tick_next;

    // Sequencer and work registers
    cdf_pkg::back_state_t            state_reg, state_next;
    logic [15:0]                     p_reg, p_next;
    logic [cdf_pkg::DIV_W-1:0]       quot_reg, quot_next;
    logic [cdf_pkg::DUR_W-1:0]       rem_reg, rem_next;
    logic [cdf_pkg::DUR_W-1:0]       span_reg, span_next;
    logic                            neg_reg, neg_next;
    logic [cdf_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;

    // Result register
    logic                            out_valid_reg, out_valid_next;
    logic [cdf_pkg::BYTE_W-1:0]      scaled_reg, scaled_next;
    cdf_pkg::status_t                status_reg, status_next;
    logic [cdf_pkg::LVL_W-1:0]       cur_level_reg, cur_level_next;
    logic                            fade_run_reg, fade_run_next;

    // Datapath signals
    logic                            out_free;
    logic                            load;
    logic [cdf_pkg::BYTE_W-1:0]      res_scaled;
    cdf_pkg::status_t                res_status;
    logic signed [10:0]              lv_ext;
    logic signed [10:0]              target;
    logic                            target_high;
    logic                            target_low;
    logic [32:0]                     fin_sum;
    logic [cdf_pkg::TIME_W-1:0]      fin_sat;
    logic [cdf_pkg::TIME_W-1:0]      span_full;
    logic signed [32:0]              elapsed;
    logic signed [8:0]               delta;
    logic signed [41:0]              product;
    logic signed [41:0]              product_neg;
    logic [cdf_pkg::DIV_W-1:0]       prod_mag;
    logic [15:0]                     p_mul;
    logic [16:0]                     round_x;
    logic [33:0]                     recip;
    logic [10:0]                     quot100;
    logic [cdf_pkg::BYTE_W-1:0]      scale_res;
    logic [25:0]                     trial;
    logic                            trial_ge;
    logic signed [41:0]              q_signed;
    logic signed [41:0]              q_sum;
    logic [cdf_pkg::LVL_W-1:0]       fade_lvl;

    assign out_free = !out_valid_reg || !out_stall;

    // Level request target and range check
    assign lv_ext      = {{2{head.level_value[cdf_pkg::LVIN_W-1]}}, head.level_value};
    assign target      = (head.op == cdf_pkg::OP_ADJUST) ?
                         ($signed({3'b000, level_reg}) + lv_ext) : lv_ext;
    assign target_high = !target[10] && (target > $signed({3'b000, cdf_pkg::LEVEL_MAX}));
    assign target_low  = target[10];

    // Fade finish time, saturated
    assign fin_sum = {1'b0, last_tick_reg} + {9'b0, head.fade_ms};
    assign fin_sat = fin_sum[32] ? '1 : fin_sum[31:0];

    // Fade interpolation product
    assign span_full   = fade_finish_time_reg - fade_begin_time_reg;
    assign elapsed     = $signed({1'b0, head.now_ms}) - $signed({1'b0, fade_begin_time_reg});
    assign delta       = $signed({1'b0, fade_target_level_reg})
                         - $signed({1'b0, fade_begin_level_reg});
    assign product     = elapsed * delta;
    assign product_neg = -product;
    assign prod_mag    = product[41] ? product_neg[cdf_pkg::DIV_W-1:0]
                                     : product[cdf_pkg::DIV_W-1:0];

    // Sample scaling: multiply, then rounded divide by 100
    assign p_mul   = head.value * level_reg;
    assign round_x = {1'b0, p_reg} + cdf_pkg::ROUND_BIAS;
    assign recip   = round_x * cdf_pkg::RECIP_MUL;
    assign quot100 = recip[33:cdf_pkg::RECIP_SHIFT];

    always_comb
    begin
        if (quot100 == '0 && p_reg >= cdf_pkg::MIN_BOOST)
            scale_res = 8'd1;
        else if (quot100 > {3'b000, cdf_pkg::BYTE_MAX})
            scale_res = cdf_pkg::BYTE_MAX;
        else
            scale_res = quot100[7:0];
    end

    // Restoring divider step
    assign trial    = {1'b0, rem_reg, quot_reg[cdf_pkg::DIV_W-1]} - {2'b00, span_reg};
    assign trial_ge = !trial[25];

    // Apply sign, add begin level and clamp
    assign q_signed = neg_reg ? -$signed({1'b0, quot_reg}) : $signed({1'b0, quot_reg});
    assign q_sum    = q_signed + $signed({34'b0, fade_begin_level_reg});

    always_comb
    begin
        if (q_sum[41])
            fade_lvl = '0;
        else if (q_sum > $signed({34'b0, cdf_pkg::LEVEL_MAX}))
            fade_lvl = cdf_pkg::LEVEL_MAX;
        else
            fade_lvl = q_sum[7:0];
    end

    // Next state and results
    always_comb
    begin
        level_next             = level_reg;
        fade_on_next           = fade_on_reg;
        fade_begin_time_next   = fade_begin_time_reg;
        fade_finish_time_next  = fade_finish_time_reg;
        fade_begin_level_next  = fade_begin_level_reg;
        fade_target_level_next = fade_target_level_reg;
        last_tick_next         = last_tick_reg;
        state_next             = state_reg;
        p_next                 = p_reg;
        quot_next              = quot_reg;
        rem_next               = rem_reg;
        span_next              = span_reg;
        neg_next               = neg_reg;
        cnt_next               = cnt_reg;
        pop                    = 1'b0;
        load                   = 1'b0;
        res_scaled             = '0;
        res_status             = cdf_pkg::STAT_OK;

        case (state_reg)
            cdf_pkg::ST_IDLE:
            begin
                if (head_valid)
                begin
                    case (head.op)
                        cdf_pkg::OP_SAMPLE:
                        begin
                            if (head.excl)
                            begin
                                if (out_free)
                                begin
                                    res_scaled = head.value;
                                    load       = 1'b1;
                                end
                            end
                            else
                            begin
                                p_next     = p_mul;
                                state_next = cdf_pkg::ST_SCALE;
                            end
                        end
                        cdf_pkg::OP_TICK:
                        begin
                            if (!fade_on_reg)
                            begin
                                if (out_free)
                                begin
                                    last_tick_next = head.now_ms;
                                    load           = 1'b1;
                                end
                            end
                            else if (head.now_ms >= fade_finish_time_reg)
                            begin
                                if (out_free)
                                begin
                                    fade_on_next   = 1'b0;
                                    level_next     = fade_target_level_reg;
                                    last_tick_next = head.now_ms;
                                    load           = 1'b1;
                                end
                            end
                            else if (fade_finish_time_reg == fade_begin_time_reg)
                            begin
                                if (out_free)
                                begin
                                    level_next     = fade_begin_level_reg;
                                    last_tick_next = head.now_ms;
                                    load           = 1'b1;
                                end
                            end
                            else
                            begin
                                quot_next  = prod_mag;
                                rem_next   = '0;
                                span_next  = span_full[cdf_pkg::DUR_W-1:0];
                                neg_next   = product[41];
                                cnt_next   = '0;
                                state_next = cdf_pkg::ST_DIV;
                            end
                        end
                        cdf_pkg::OP_SET, cdf_pkg::OP_ADJUST, cdf_pkg::OP_FADE:
                        begin
                            if (out_free)
                            begin
                                load = 1'b1;
                                if (target_high)
                                    res_status = cdf_pkg::STAT_HIGH;
                                else if (target_low)
                                    res_status = cdf_pkg::STAT_LOW;
                                else if (head.op == cdf_pkg::OP_FADE)
                                begin
                                    fade_begin_level_next  = level_reg;
                                    fade_target_level_next = target[7:0];
                                    fade_begin_time_next   = last_tick_reg;
                                    fade_finish_time_next  = fin_sat;
                                    fade_on_next           = 1'b1;
                                end
                                else
                                begin
                                    fade_on_next = 1'b0;
                                    level_next   = target[7:0];
                                end
                            end
                        end
                        default:
                        begin
                            if (out_free)
                                load = 1'b1;
                        end
                    endcase
                end
            end
            cdf_pkg::ST_SCALE:
            begin
                if (out_free)
                begin
                    res_scaled = scale_res;
                    load       = 1'b1;
                    state_next = cdf_pkg::ST_IDLE;
                end
            end
            cdf_pkg::ST_DIV:
            begin
                quot_next = {quot_reg[cdf_pkg::DIV_W-2:0], trial_ge};
                rem_next  = trial_ge ? trial[cdf_pkg::DUR_W-1:0]
                                     : {rem_reg[cdf_pkg::DUR_W-2:0],
                                        quot_reg[cdf_pkg::DIV_W-1]};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == cdf_pkg::DIV_LAST)
                    state_next = cdf_pkg::ST_FIX;
            end
            cdf_pkg::ST_FIX:
            begin
                if (out_free)
                begin
                    level_next     = fade_lvl;
                    last_tick_next = head.now_ms;
                    load           = 1'b1;
                    state_next     = cdf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cdf_pkg::ST_IDLE;
            end
        endcase

        // Retire the head command with its result
        pop = load;

        // Load or drain the result register
        out_valid_next = load ? 1'b1 : (out_valid_reg && out_stall);
        scaled_next    = load ? res_scaled   : scaled_reg;
        status_next    = load ? res_status   : status_reg;
        cur_level_next = load ? level_next   : cur_level_reg;
        fade_run_next  = load ? fade_on_next : fade_run_reg;
    end

    // Control and model state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg             <= cdf_pkg::ST_IDLE;
            out_valid_reg         <= 1'b0;
            level_reg             <= cdf_pkg::LEVEL_RESET;
            fade_on_reg           <= 1'b0;
            fade_begin_time_reg   <= '0;
            fade_finish_time_reg  <= '0;
            fade_begin_level_reg  <= '0;
            fade_target_level_reg <= '0;
            last_tick_reg         <= '0;
            cnt_reg               <= '0;
        end
        else
        begin
            state_reg             <= state_next;
            out_valid_reg         <= out_valid_next;
            level_reg             <= level_next;
            fade_on_reg           <= fade_on_next;
            fade_begin_time_reg   <= fade_begin_time_next;
            fade_finish_time_reg  <= fade_finish_time_next;
            fade_begin_level_reg  <= fade_begin_level_next;
            fade_target_level_reg <= fade_target_level_next;
            last_tick_reg         <= last_tick_next;
            cnt_reg               <= cnt_next;
        end
    end

    // Work and result payload
    always_ff @(posedge clk)
    begin
        p_reg         <= p_next;
        quot_reg      <= quot_next;
        rem_reg       <= rem_next;
        span_reg      <= span_next;
        neg_reg       <= neg_next;
        scaled_reg    <= scaled_next;
        status_reg    <= status_next;
        cur_level_reg <= cur_level_next;
        fade_run_reg  <= fade_run_next;
    end

    assign out_valid     = out_valid_reg;
    assign scaled_value  = scaled_reg;
    assign status        = status_reg;
    assign current_level = cur_level_reg;
    assign fade_running  = fade_run_reg;

endmodule

>>> src/channel_dimmer_with_fade.sv
// Results: set, adjust, fade, plain ticks and excluded samples load the result register
// straight from the idle state; scaled samples pass a scale state (multiply, then divide by 100).
// A tick inside a running fade passes a 41-step restoring divider and then a fix state.
// The back end takes no new command while a scaled sample or a fade tick is in progress.
// Reset: asynchronous, active low; level 100, no fade, exclude ranges empty.
// ----------------------------------------------------------------------------
// channel_dimmer_with_fade
// Dims light-channel bytes by a 0..200 percent level with linear fades; front
// decoder, command queue and back executor.
// ----------------------------------------------------------------------------
module channel_dimmer_with_fade (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cdf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cdf_pkg::CHAN_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [2:0]                    req_type,
    input  logic [cdf_pkg::CHAN_W-1:0]    channel_index,
    input  logic [cdf_pkg::BYTE_W-1:0]    channel_value,
    input  logic [cdf_pkg::LVIN_W-1:0]    level_value,
    input  logic [cdf_pkg::DUR_W-1:0]     fade_ms,
    input  logic [cdf_pkg::TIME_W-1:0]    now_ms,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [cdf_pkg::BYTE_W-1:0]    scaled_value,
    output logic [1:0]                    status,
    output logic [cdf_pkg::LVL_W-1:0]     current_level,
    output logic                          fade_running
);

    cdf_pkg::cmd_t front_cmd;
    cdf_pkg::cmd_t head_cmd;
    logic          q_full;
    logic          q_valid;
    logic          q_pop;
    logic          q_push;

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    cdf_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .req_type      (req_type),
        .channel_index (channel_index),
        .channel_value (channel_value),
        .level_value   (level_value),
        .fade_ms       (fade_ms),
        .now_ms        (now_ms),
        .cmd           (front_cmd)
    );

    cdf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (front_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head       (head_cmd)
    );

    cdf_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (q_valid),
        .head          (head_cmd),
        .pop           (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .scaled_value  (scaled_value),
        .status        (status),
        .current_level (current_level),
        .fade_running  (fade_running)
    );

endmodule

>>> src/cdf_checker.sv
// ----------------------------------------------------------------------------
// cdf_port_checks
// Port-level checks on the dimmer results, bound to the top level.
// ----------------------------------------------------------------------------
module cdf_port_checks (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [cdf_pkg::BYTE_W-1:0]    scaled_value,
    input logic [1:0]                    status,
    input logic [cdf_pkg::LVL_W-1:0]     current_level,
    input logic                          fade_running
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(scaled_value)
            && $stable(status) && $stable(current_level) && $stable(fade_running))
        else $error("stalled result changed");

    // Level never leaves 0..200
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> current_level <= cdf_pkg::LEVEL_MAX)
        else $error("level above maximum");

    // Rejected requests carry no channel byte
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != 2'(cdf_pkg::STAT_OK)) |-> scaled_value == '0)
        else $error("rejected request with nonzero byte");

    // A rejected request leaves the level and the fade flag unchanged from the prior transfer
    a_reject_keeps_level: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall ##1 out_valid && (status != 2'(cdf_pkg::STAT_OK))
        |-> current_level == $past(current_level) && fade_running == $past(fade_running))
        else $error("rejected request changed state");

endmodule

bind channel_dimmer_with_fade cdf_port_checks u_port_checks (.*);

>>> verif/cdf_checker.sv
// ----------------------------------------------------------------------------
// cdf_checker
// Watches the configuration, request and result channels of the channel
// dimmer, keeps its own copy of the dimmer state, predicts the result of
// every request transfer and compares each result transfer field by field.
// ----------------------------------------------------------------------------
module cdf_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [cdf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cdf_pkg::CHAN_W-1:0]    cfg_data,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [2:0]                    req_type,
    input  logic [cdf_pkg::CHAN_W-1:0]    channel_index,
    input  logic [cdf_pkg::BYTE_W-1:0]    channel_value,
    input  logic [cdf_pkg::LVIN_W-1:0]    level_value,
    input  logic [cdf_pkg::DUR_W-1:0]     fade_ms,
    input  logic [cdf_pkg::TIME_W-1:0]    now_ms,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [cdf_pkg::BYTE_W-1:0]    scaled_value,
    input  logic [1:0]                    status,
    input  logic [cdf_pkg::LVL_W-1:0]     current_level,
    input  logic                          fade_running,
    output int unsigned                   errors,
    output int unsigned                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import cdf_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] scaled;
        status_t           stat;
        logic [LVL_W-1:0]  lvl;
        logic              fading;
    } dim_result_t;

    // Exclude ranges as last written
    logic [CHAN_W-1:0] first_a, last_a, first_b, last_b;

    // Dimmer state
    logic [LVL_W-1:0]  lvl;
    logic              fading;
    logic [TIME_W-1:0] fade_t0, fade_t1, tick_time;
    logic [LVL_W-1:0]  fade_lvl0, fade_lvl1;

    dim_result_t due_results[$];

    function automatic bit excluded(logic [CHAN_W-1:0] idx);
        return (first_a <= last_a && idx >= first_a && idx <= last_a) ||
               (first_b <= last_b && idx >= first_b && idx <= last_b);
    endfunction

    // Advance the dimmer state by one request and return its result
    function automatic dim_result_t dimmer_step(
        logic [2:0]              req,
        logic [CHAN_W-1:0]       idx,
        logic [BYTE_W-1:0]       val,
        logic signed [LVIN_W-1:0] lv,
        logic [DUR_W-1:0]        dur,
        logic [TIME_W-1:0]       now
    );
        dim_result_t r;
        int unsigned p, s;
        int          target;
        longint      elapsed, span, delta, q, nl, fin;
        r = '0;
        r.stat = STAT_OK;
        case (req)
            REQ_SAMPLE:
            begin
                if (excluded(idx))
                    r.scaled = val;
                else
                begin
                    // round half up, keep faint channels lit, clip at full scale
                    p = int'(val) * int'(lvl);
                    s = (p + 50) / 100;
                    if (s == 0 && p >= 20)
                        s = 1;
                    if (s > int'(BYTE_MAX))
                        s = int'(BYTE_MAX);
                    r.scaled = s[BYTE_W-1:0];
                end
            end
            REQ_TICK:
            begin
                tick_time = now;
                if (fading)
                begin
                    if (now >= fade_t1)
                    begin
                        fading = 1'b0;
                        lvl    = fade_lvl1;
                    end
                    else
                    begin
                        // linear ramp, quotient truncated toward zero
                        elapsed = longint'(now) - longint'(fade_t0);
                        span    = longint'(fade_t1) - longint'(fade_t0);
                        delta   = longint'(fade_lvl1) - longint'(fade_lvl0);
                        q = 0;
                        if (span > 0)
                            q = (elapsed * delta) / span;
                        nl = q + longint'(fade_lvl0);
                        if (nl < 0)
                            lvl = '0;
                        else if (nl > longint'(LEVEL_MAX))
                            lvl = LEVEL_MAX;
                        else
                            lvl = nl[LVL_W-1:0];
                    end
                end
            end
            REQ_SET, REQ_ADJUST, REQ_FADE:
            begin
                target = (req == REQ_ADJUST) ? int'(lvl) + int'(lv) : int'(lv);
                if (target > int'(LEVEL_MAX))
                    r.stat = STAT_HIGH;
                else if (target < 0)
                    r.stat = STAT_LOW;
                else if (req == REQ_FADE)
                begin
                    // finish time saturates at the top of the time range
                    fin       = longint'(tick_time) + longint'(dur);
                    fade_lvl0 = lvl;
                    fade_lvl1 = target[LVL_W-1:0];
                    fade_t0   = tick_time;
                    fade_t1   = (fin > longint'(32'hFFFF_FFFF)) ? '1 : fin[TIME_W-1:0];
                    fading    = 1'b1;
                end
                else
                begin
                    fading = 1'b0;
                    lvl    = target[LVL_W-1:0];
                end
            end
            default:
            begin
                // unknown request: no effect
            end
        endcase
        r.lvl    = lvl;
        r.fading = fading;
        return r;
    endfunction

    function automatic bit field_ok(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // Track config, check results, then queue the prediction of a new request
    always @(posedge clk or negedge rst_n)
    begin : monitor
        dim_result_t want;
        if (!rst_n)
        begin
            first_a   = '1;
            last_a    = '0;
            first_b   = '1;
            last_b    = '0;
            lvl       = LEVEL_RESET;
            fading    = 1'b0;
            fade_t0   = '0;
            fade_t1   = '0;
            tick_time = '0;
            fade_lvl0 = '0;
            fade_lvl1 = '0;
            due_results.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_FIRST_A: first_a = cfg_data;
                    CFG_LAST_A:  last_a  = cfg_data;
                    CFG_FIRST_B: first_b = cfg_data;
                    CFG_LAST_B:  last_b  = cfg_data;
                    default:     ;
                endcase
            end

            if (out_valid && !out_stall)
            begin
                if (due_results.size() == 0)
                begin
                    $display({"%0t: result transfer with nothing expected: ",
                              "expected none, actual %0d %0d %0d %0d"},
                             $time, scaled_value, status, current_level, fade_running);
                    errors++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (!field_ok("scaled_value", want.scaled, scaled_value))
                        errors++;
                    if (!field_ok("status", 8'(want.stat), 8'(status)))
                        errors++;
                    if (!field_ok("current_level", want.lvl, current_level))
                        errors++;
                    if (!field_ok("fade_running", 8'(want.fading), 8'(fade_running)))
                        errors++;
                end
            end

            if (in_valid && !in_stall)
                due_results.insert(due_results.size(),
                                   dimmer_step(req_type, channel_index, channel_value,
                                               level_value, fade_ms, now_ms));

            pending = due_results.size();
        end
    end

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the channel dimmer with directed and random requests across several
// exclude-range settings, with random idle bursts on both channels and one
// long result hold-off; a side checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cdf_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 205;

    typedef struct packed {
        logic [2:0]        req;
        logic [CHAN_W-1:0] idx;
        logic [BYTE_W-1:0] val;
        logic [LVIN_W-1:0] lv;
        logic [DUR_W-1:0]  dur;
        logic [TIME_W-1:0] now;
    } dim_req_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CHAN_W-1:0]    cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [2:0]           req_type;
    logic [CHAN_W-1:0]    channel_index;
    logic [BYTE_W-1:0]    channel_value;
    logic [LVIN_W-1:0]    level_value;
    logic [DUR_W-1:0]     fade_ms;
    logic [TIME_W-1:0]    now_ms;
    logic                 out_valid;
    logic                 out_stall;
    logic [BYTE_W-1:0]    scaled_value;
    logic [1:0]           status;
    logic [LVL_W-1:0]     current_level;
    logic                 fade_running;

    int unsigned       errors;
    int unsigned       pending;
    int unsigned       gap_odds;
    bit                calm;
    bit                squeeze_req;
    logic [TIME_W-1:0] clock_ms;
    logic [CHAN_W-1:0] excl_cfg [4];
    int                quiet_cycles;

    channel_dimmer_with_fade i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .channel_index (channel_index),
        .channel_value (channel_value),
        .level_value   (level_value),
        .fade_ms       (fade_ms),
        .now_ms        (now_ms),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .scaled_value  (scaled_value),
        .status        (status),
        .current_level (current_level),
        .fade_running  (fade_running)
    );

    cdf_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .channel_index (channel_index),
        .channel_value (channel_value),
        .level_value   (level_value),
        .fade_ms       (fade_ms),
        .now_ms        (now_ms),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .scaled_value  (scaled_value),
        .status        (status),
        .current_level (current_level),
        .fade_running  (fade_running),
        .errors        (errors),
        .pending       (pending)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abort when no transfer of any kind happens for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("DONE: errors detected");
                    $finish;
                end
            end
        end
    end

    // Result side: random stall bursts, one long hold-off, none when calm
    initial
    begin : receiver
        int stall_odds;
        int window;
        bit squeeze_done;
        out_stall    = 1'b0;
        stall_odds   = 0;
        window       = 0;
        squeeze_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (window == 0)
            begin
                window = 150;
                case ($urandom_range(0, 2))
                    0:       stall_odds = 0;
                    1:       stall_odds = 4;
                    default: stall_odds = 12;
                endcase
            end
            window--;
            if (squeeze_req && !squeeze_done)
            begin
                squeeze_done = 1'b1;
                out_stall = 1'b1;
                repeat (300) @(negedge clk);
                out_stall = 1'b0;
            end
            else if (!calm && stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
            begin
                out_stall = 1'b1;
                repeat ($urandom_range(1, 15)) @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    function automatic dim_req_t pack_req(logic [2:0] req, int unsigned idx, int unsigned val,
                                          int lv, int unsigned dur, int unsigned now);
        dim_req_t r;
        r.req = req;
        r.idx = CHAN_W'(idx);
        r.val = BYTE_W'(val);
        r.lv  = LVIN_W'(lv);
        r.dur = DUR_W'(dur);
        r.now = TIME_W'(now);
        return r;
    endfunction

    // Random request: mostly samples near range edges, ticks moving forward, level changes
    function automatic dim_req_t pick_request();
        dim_req_t r;
        int       k;
        int       d;
        r.req = REQ_SAMPLE;
        r.idx = CHAN_W'($urandom());
        r.val = BYTE_W'($urandom());
        r.lv  = LVIN_W'($urandom());
        r.dur = DUR_W'($urandom());
        r.now = $urandom();
        k = $urandom_range(0, 99);
        if (k < 50)
        begin
            r.req = REQ_SAMPLE;
            if ($urandom_range(0, 2) != 0)
                r.idx = CHAN_W'(excl_cfg[2'($urandom_range(0, 3))]
                                + $urandom_range(0, 2) - 1);
            if ($urandom_range(0, 7) == 0)
                r.val = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        else if (k < 68)
        begin
            r.req = REQ_TICK;
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13:
                    clock_ms = clock_ms + $urandom_range(0, 400);
                14, 15:  clock_ms = clock_ms - $urandom_range(1, 600);
                16:      ;
                17:      clock_ms = $urandom();
                18:      clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
                default: clock_ms = $urandom_range(0, 1000);
            endcase
            r.now = clock_ms;
        end
        else if (k < 76)
        begin
            r.req = REQ_SET;
            if ($urandom_range(0, 4) != 0)
                r.lv = LVIN_W'($urandom_range(0, 200));
        end
        else if (k < 84)
        begin
            r.req = REQ_ADJUST;
            if ($urandom_range(0, 4) != 0)
            begin
                d = int'($urandom_range(0, 120)) - 60;
                r.lv = LVIN_W'(d);
            end
        end
        else if (k < 97)
        begin
            r.req = REQ_FADE;
            if ($urandom_range(0, 6) != 0)
                r.lv = LVIN_W'($urandom_range(0, 200));
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: r.dur = DUR_W'($urandom_range(0, 2000));
                6:                r.dur = '0;
                7, 8:             r.dur = DUR_W'($urandom_range(2000, 100000));
                default:          ;
            endcase
        end
        else
            r.req = 3'($urandom_range(5, 7));
        return r;
    endfunction

    // Offer one request, with an optional idle burst ahead, and hold it until taken
    task automatic send_request(dim_req_t r);
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat ($urandom_range(0, 14)) @(negedge clk);
        end
        @(negedge clk);
        in_valid      = 1'b1;
        req_type      = r.req;
        channel_index = r.idx;
        channel_value = r.val;
        level_value   = r.lv;
        fade_ms       = r.dur;
        now_ms        = r.now;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic cfg_write(cfg_idx_t idx, logic [CHAN_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        excl_cfg[idx] = data;
    endtask

    task automatic apply_ranges(logic [CHAN_W-1:0] fa, logic [CHAN_W-1:0] la,
                                logic [CHAN_W-1:0] fb, logic [CHAN_W-1:0] lb);
        cfg_write(CFG_FIRST_A, fa);
        cfg_write(CFG_LAST_A, la);
        cfg_write(CFG_FIRST_B, fb);
        cfg_write(CFG_LAST_B, lb);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Drop valid and drain every outstanding result
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    initial
    begin : stimulus
        int               ph;
        logic [CHAN_W-1:0] base_a, base_b;
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_FIRST_A;
        cfg_data      = '0;
        in_valid      = 1'b0;
        req_type      = REQ_SAMPLE;
        channel_index = '0;
        channel_value = '0;
        level_value   = '0;
        fade_ms       = '0;
        now_ms        = '0;
        gap_odds      = 0;
        calm          = 1'b0;
        squeeze_req   = 1'b0;
        clock_ms      = '0;
        quiet_cycles  = 0;
        excl_cfg[CFG_FIRST_A] = '1;
        excl_cfg[CFG_LAST_A]  = '0;
        excl_cfg[CFG_FIRST_B] = '1;
        excl_cfg[CFG_LAST_B]  = '0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: rounding edges, rejects, fade through its corner cases
        send_request(pack_req(REQ_SAMPLE, 0, 0, 0, 0, 0));
        send_request(pack_req(REQ_SAMPLE, 24'hFFFFFF, 255, 0, 0, 0));
        send_request(pack_req(REQ_SET, 0, 0, 200, 0, 0));
        send_request(pack_req(REQ_SAMPLE, 5, 255, 0, 0, 0));
        send_request(pack_req(REQ_SET, 0, 0, 1, 0, 0));
        send_request(pack_req(REQ_SAMPLE, 7, 20, 0, 0, 0));
        send_request(pack_req(REQ_SAMPLE, 7, 19, 0, 0, 0));
        send_request(pack_req(REQ_SET, 0, 0, 0, 0, 0));
        send_request(pack_req(REQ_SAMPLE, 9, 255, 0, 0, 0));
        send_request(pack_req(REQ_SET, 0, 0, 201, 0, 0));
        send_request(pack_req(REQ_SET, 0, 0, -1, 0, 0));
        send_request(pack_req(REQ_ADJUST, 0, 0, 255, 0, 0));
        send_request(pack_req(REQ_ADJUST, 0, 0, -256, 0, 0));
        send_request(pack_req(REQ_ADJUST, 0, 0, 150, 0, 0));
        send_request(pack_req(REQ_TICK, 0, 0, 0, 0, 1000));
        send_request(pack_req(REQ_FADE, 0, 0, 50, 1000, 0));
        send_request(pack_req(REQ_TICK, 0, 0, 0, 0, 1500));
        send_request(pack_req(REQ_SET, 0, 0, 250, 0, 0));
        send_request(pack_req(REQ_TICK, 0, 0, 0, 0, 900));
        send_request(pack_req(REQ_TICK, 0, 0, 0, 0, 2000));
        send_request(pack_req(REQ_TICK, 0, 0, 0, 0, 32'hFFFF_FF00));
        send_request(pack_req(REQ_FADE, 0, 0, 200, 24'hFFFFFF, 0));
        send_request(pack_req(REQ_TICK, 0, 0, 0, 0, 32'hFFFF_FFF0));
        send_request(pack_req(REQ_FADE, 0, 0, 10, 0, 0));
        send_request(pack_req(REQ_TICK, 0, 0, 0, 0, 32'hFFFF_FF00));
        send_request(pack_req(3'd7, 0, 0, 0, 0, 0));
        settle();

        // Random phases, each under its own exclude ranges
        for (ph = 0; ph < PHASES; ph++)
        begin
            base_a = CHAN_W'($urandom());
            base_b = CHAN_W'($urandom());
            case (ph)
                0:       apply_ranges(24'd100, 24'd200, 24'd1000, 24'd1000);
                1:       apply_ranges(24'd0, 24'hFFFFFF, 24'hFFFFFF, 24'd0);
                2:       apply_ranges(24'd0, 24'd0, 24'hFFFFFF, 24'hFFFFFF);
                3:       apply_ranges(24'd5, 24'd4, 24'd0, 24'h7FFFFF);
                default: apply_ranges(base_a, CHAN_W'(base_a + $urandom_range(0, 5000)),
                                      base_b, CHAN_W'(base_b + $urandom_range(0, 300)));
            endcase
            case ($urandom_range(0, 2))
                0:       gap_odds = 0;
                1:       gap_odds = 3;
                default: gap_odds = 8;
            endcase
            // fill the block against a held-off result side
            if (ph == 2)
            begin
                squeeze_req = 1'b1;
                gap_odds    = 0;
            end
            if (ph == PHASES - 1)
            begin
                calm     = 1'b1;
                gap_odds = 0;
            end
            repeat (PHASE_ITEMS) send_request(pick_request());
            settle();
        end

        repeat (60) @(negedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
